// ===== hw/rtl/lifo_stack_with_peek_and_flip_top_macros.svh =====
// ----------------------------------------------------------------------------
// lifo stack assertion macros
// immediate-style wrappers for concurrent checks, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_PEEK_AND_FLIP_TOP_MACROS_SVH
`define LIFO_STACK_WITH_PEEK_AND_FLIP_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define LSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lifo stack check failed");
// next-cycle implication
`define LSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lifo stack check failed");
`else
`define LSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/lsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lsf_pkg
// shared types and codes for the lifo stack with peek and flip
// ----------------------------------------------------------------------------
package lsf_pkg;

    localparam int DEFAULT_DEPTH  = 256;
    localparam int DEFAULT_DATA_W = 32;

    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 9;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FLIP  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INDEX = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [VALUE_W-1:0] push_value;
        logic [INDEX_W-1:0] peek_index;
    } t_req;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_data;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
        logic                is_empty;
    } t_rsp;

    // strobes from the control logic to the entry store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_cmd;

endpackage

// ===== hw/rtl/lsf_store.sv =====
// ----------------------------------------------------------------------------
// lsf_store
// circular entry store with position to slot mapping, registered read
// ----------------------------------------------------------------------------
module lsf_store #(
    parameter int DEPTH  = lsf_pkg::DEFAULT_DEPTH,
    parameter int DATA_W = lsf_pkg::DEFAULT_DATA_W
) (
    input  logic                     i_clk,
    input  lsf_pkg::t_mem_cmd        i_cmd,
    input  logic [$clog2(DEPTH)-1:0] i_bottom,
    input  logic                     i_down,
    input  logic [$clog2(DEPTH)-1:0] i_pos,
    input  logic [DATA_W-1:0]        i_wdata,
    output logic [$clog2(DEPTH)-1:0] o_slot,
    output logic [DATA_W-1:0]        o_rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic [AW:0]       sum_up;
    logic [AW:0]       sum_dn;
    logic [AW:0]       slot_w;

    // bottom plus or minus position, wrapped once into the store
    always_comb begin
        sum_up = {1'b0, i_bottom} + {1'b0, i_pos};
        sum_dn = {1'b0, i_bottom} - {1'b0, i_pos};
        if (i_down) begin
            slot_w = sum_dn[AW] ? (sum_dn + (AW+1)'(DEPTH)) : sum_dn;
        end else begin
            slot_w = (sum_up >= (AW+1)'(DEPTH)) ? (sum_up - (AW+1)'(DEPTH)) : sum_up;
        end
    end

    assign o_slot = slot_w[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[o_slot] <= i_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[o_slot];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lifo_stack_with_peek_and_flip_top.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_peek_and_flip_top
// one item at a time: idle takes it, busy holds ready low until the output register takes the result
// the single-port entry store reads in the accept cycle and registers the data for busy
// reset (sync, active low) empties the stack and clears direction; store not cleared
// ----------------------------------------------------------------------------
`include "lifo_stack_with_peek_and_flip_top_macros.svh"

module lifo_stack_with_peek_and_flip_top #(
    parameter int DEPTH  = lsf_pkg::DEFAULT_DEPTH,
    parameter int DATA_W = lsf_pkg::DEFAULT_DATA_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  lsf_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output lsf_pkg::t_rsp o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);
    // common width for count and index compares
    localparam int CW = (OW > lsf_pkg::INDEX_W) ? OW : lsf_pkg::INDEX_W;

    // one-hot control: idle takes an item, busy waits for store data and output slot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } t_state;

    t_state                      r_state, n_state;
    logic [OW-1:0]               r_occ, n_occ;
    logic [AW-1:0]               r_bottom, n_bottom;
    logic                        r_down, n_down;
    logic [lsf_pkg::STATUS_W-1:0] r_status, n_status;
    logic                        r_use_data, n_use_data;
    logic                        r_out_valid;
    lsf_pkg::t_rsp               r_rsp;

    logic                        req_acc;
    logic                        rsp_load;
    logic [CW-1:0]               occ_c;
    logic [CW-1:0]               idx_c;
    logic [CW-1:0]               pos_c;
    logic [63:0]                 wval_64;
    logic [63:0]                 rval_64;
    lsf_pkg::t_mem_cmd           mem_cmd;
    logic [AW-1:0]               slot;
    logic [DATA_W-1:0]           rdata;
    logic                        pop_taken;
    logic                        over_load;

    assign o_req_ready = (r_state == S_IDLE);
    assign req_acc     = i_req_valid && o_req_ready;
    // result leaves busy once the output register is free or being emptied
    assign rsp_load    = (r_state == S_BUSY) && (!r_out_valid || i_rsp_ready);

    assign occ_c = CW'(r_occ);
    assign idx_c = CW'(i_req.peek_index);

    // position counted from the bottom for the entry this item touches
    always_comb begin
        case (i_req.req_type)
            lsf_pkg::REQ_PUSH: pos_c = occ_c;
            lsf_pkg::REQ_PEEK: pos_c = occ_c - idx_c;
            default:           pos_c = occ_c - CW'(1);
        endcase
    end

    // push word, kept to DATA_W bits
    assign wval_64 = 64'(i_req.push_value);

    // request decode and pointer update
    always_comb begin
        n_occ      = r_occ;
        n_bottom   = r_bottom;
        n_down     = r_down;
        n_status   = r_status;
        n_use_data = r_use_data;
        mem_cmd    = '0;
        if (req_acc) begin
            n_status    = lsf_pkg::ST_OK;
            n_use_data  = 1'b0;
            mem_cmd.rd_en = 1'b1;
            case (i_req.req_type)
                lsf_pkg::REQ_PUSH: begin
                    if (occ_c >= CW'(DEPTH)) begin
                        n_status = lsf_pkg::ST_OVER;
                    end else begin
                        mem_cmd.wr_en = 1'b1;
                        n_occ = r_occ + OW'(1);
                    end
                end
                lsf_pkg::REQ_POP: begin
                    if (r_occ == '0) begin
                        n_status = lsf_pkg::ST_UNDER;
                    end else begin
                        n_occ      = r_occ - OW'(1);
                        n_use_data = 1'b1;
                    end
                end
                lsf_pkg::REQ_PEEK: begin
                    if (r_occ == '0) begin
                        n_status = lsf_pkg::ST_UNDER;
                    end else if (idx_c == '0 || idx_c > occ_c) begin
                        n_status = lsf_pkg::ST_INDEX;
                    end else begin
                        n_use_data = 1'b1;
                    end
                end
                lsf_pkg::REQ_FLIP: begin
                    // old top becomes the bottom, growth reverses
                    if (occ_c > CW'(1)) begin
                        n_bottom = slot;
                        n_down   = !r_down;
                    end
                end
                lsf_pkg::REQ_CLEAR: begin
                    n_occ    = '0;
                    n_bottom = '0;
                    n_down   = 1'b0;
                end
                default: begin
                    // unused codes leave everything alone
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (req_acc) n_state = S_BUSY;
            S_BUSY:  if (rsp_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    lsf_store #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_cmd    (mem_cmd),
        .i_bottom (r_bottom),
        .i_down   (r_down),
        .i_pos    (pos_c[AW-1:0]),
        .i_wdata  (wval_64[DATA_W-1:0]),
        .o_slot   (slot),
        .o_rdata  (rdata)
    );

    assign rval_64 = 64'(rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_bottom    <= '0;
            r_down      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_bottom <= n_bottom;
            r_down   <= n_down;
            if (rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-item status and the output register, no reset needed
    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_use_data <= n_use_data;
        if (rsp_load) begin
            r_rsp.read_data   <= r_use_data ? rval_64[lsf_pkg::VALUE_W-1:0] : '0;
            r_rsp.status      <= r_status;
            r_rsp.entry_count <= occ_c[lsf_pkg::COUNT_W-1:0];
            r_rsp.is_empty    <= (r_occ == '0);
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

    assign pop_taken = req_acc && i_req.req_type == lsf_pkg::REQ_POP && r_occ != '0;
    assign over_load = rsp_load && r_status == lsf_pkg::ST_OVER;

    // a successful pop drops the count by exactly one
    `LSF_ASSERT_NXT(a_pop_dec, i_clk, i_rst_n, pop_taken, r_occ == $past(r_occ) - OW'(1))
    // an accepted item always holds ready low in the cycle after
    `LSF_ASSERT_NXT(a_busy_after_acc, i_clk, i_rst_n, req_acc, !o_req_ready)
    // overflow is only ever reported on a full stack
    `LSF_ASSERT_IMP(a_over_full, i_clk, i_rst_n, over_load, occ_c == CW'(DEPTH))

endmodule

// ===== tb/lsf_stack_checker.sv =====
// ----------------------------------------------------------------------------
// lsf_stack_checker
// watches both channels of the lifo stack, keeps a shadow copy of the stack,
// and compares every response item with the one the shadow stack predicts
// ----------------------------------------------------------------------------
module lsf_stack_checker #(
    parameter int DEPTH = lsf_pkg::DEFAULT_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_ready,
    input  lsf_pkg::t_req i_req,
    input  logic          i_rsp_valid,
    input  logic          i_rsp_ready,
    input  lsf_pkg::t_rsp i_rsp,
    output int            o_errors,
    output int            o_pending,
    output int            o_checked,
    output int            o_overflows,
    output int            o_underflows,
    output int            o_bad_index
);
    timeunit 1ns;
    timeprecision 1ps;

    import lsf_pkg::*;

    // shadow stack: circular store, bottom slot and direction
    logic [VALUE_W-1:0] shadow_mem [DEPTH];
    int                 shadow_count;
    int                 shadow_base;
    bit                 shadow_down;

    t_rsp awaited_rsp [$];
    int   n_errors;
    int   n_checked;
    int   status_seen [4];

    assign o_errors     = n_errors;
    assign o_checked    = n_checked;
    assign o_overflows  = status_seen[ST_OVER];
    assign o_underflows = status_seen[ST_UNDER];
    assign o_bad_index  = status_seen[ST_INDEX];

    initial begin
        shadow_count = 0;
        shadow_base  = 0;
        shadow_down  = 1'b0;
        n_errors     = 0;
        n_checked    = 0;
        foreach (status_seen[s]) status_seen[s] = 0;
    end

    // slot of the entry k places above the bottom
    function automatic int slot_at(input int k);
        if (shadow_down) begin
            return (shadow_base + DEPTH - (k % DEPTH)) % DEPTH;
        end
        return (shadow_base + k) % DEPTH;
    endfunction

    // applies one request to the shadow stack and returns the response it should give
    function automatic t_rsp apply_request(input t_req r);
        t_rsp p;
        p        = '0;
        p.status = ST_OK;
        case (r.req_type)
            REQ_PUSH: begin
                if (shadow_count >= DEPTH) begin
                    p.status = ST_OVER;
                end else begin
                    shadow_mem[slot_at(shadow_count)] = r.push_value;
                    shadow_count++;
                end
            end
            REQ_POP: begin
                if (shadow_count == 0) begin
                    p.status = ST_UNDER;
                end else begin
                    shadow_count--;
                    p.read_data = shadow_mem[slot_at(shadow_count)];
                end
            end
            REQ_PEEK: begin
                if (shadow_count == 0) begin
                    p.status = ST_UNDER;
                end else if (r.peek_index == 0 || int'(r.peek_index) > shadow_count) begin
                    p.status = ST_INDEX;
                end else begin
                    p.read_data = shadow_mem[slot_at(shadow_count - int'(r.peek_index))];
                end
            end
            REQ_FLIP: begin
                if (shadow_count > 1) begin
                    shadow_base = slot_at(shadow_count - 1);
                    shadow_down = !shadow_down;
                end
            end
            REQ_CLEAR: begin
                shadow_count = 0;
                shadow_base  = 0;
                shadow_down  = 1'b0;
            end
            default: begin
            end
        endcase
        p.entry_count = shadow_count[COUNT_W-1:0];
        p.is_empty    = (shadow_count == 0);
        return p;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (i_rst_n) begin
            // response side first: a result never belongs to a request taken at the same edge
            if (i_rsp_valid && i_rsp_ready) begin
                if (awaited_rsp.size() == 0) begin
                    $display("%0t: response with nothing awaited, got %h", $time, i_rsp);
                    n_errors++;
                end else begin
                    want = awaited_rsp.pop_front();
                    n_checked++;
                    status_seen[want.status]++;
                    if (i_rsp.read_data !== want.read_data) begin
                        $display("%0t: read_data expected %h got %h",
                                 $time, want.read_data, i_rsp.read_data);
                        n_errors++;
                    end
                    if (i_rsp.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, i_rsp.status);
                        n_errors++;
                    end
                    if (i_rsp.entry_count !== want.entry_count) begin
                        $display("%0t: entry_count expected %0d got %0d",
                                 $time, want.entry_count, i_rsp.entry_count);
                        n_errors++;
                    end
                    if (i_rsp.is_empty !== want.is_empty) begin
                        $display("%0t: is_empty expected %b got %b",
                                 $time, want.is_empty, i_rsp.is_empty);
                        n_errors++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                awaited_rsp.push_back(apply_request(i_req));
            end
        end
        o_pending <= awaited_rsp.size();
    end

endmodule

// ===== tb/tb_lifo_stack_with_peek_and_flip_top.sv =====
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_peek_and_flip_top
// drives push, pop, peek, flip and clear items into the lifo stack; a checker
// beside the block predicts every response and reports mismatches
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_peek_and_flip_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lsf_pkg::*;

    localparam int DEPTH       = DEFAULT_DEPTH;
    localparam int HALF_PERIOD = 5;
    // cycles without any item moving before the run is called hung
    localparam int STALL_LIMIT = 2000;
    // quiet cycles after the last response
    localparam int DRAIN_TAIL  = 8;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_req_valid;
    logic  o_req_ready;
    t_req  i_req;
    logic  o_rsp_valid;
    logic  i_rsp_ready;
    t_rsp  o_rsp;

    int chk_errors;
    int chk_pending;
    int chk_checked;
    int chk_overflows;
    int chk_underflows;
    int chk_bad_index;

    // rough occupancy, only used to steer peek indexes and the fill phase
    int fill;
    // when set, neither side idles
    bit quiet;
    int kind_count [1 << REQ_W];
    int idle_cycles;

    lifo_stack_with_peek_and_flip_top #(
        .DEPTH (DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    lsf_stack_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req_ready  (o_req_ready),
        .i_req        (i_req),
        .i_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .i_rsp        (o_rsp),
        .o_errors     (chk_errors),
        .o_pending    (chk_pending),
        .o_checked    (chk_checked),
        .o_overflows  (chk_overflows),
        .o_underflows (chk_underflows),
        .o_bad_index  (chk_bad_index)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // response side back-pressure: ready is drawn low at random, with 15 percent odds, unless quiet
    always @(posedge i_clk) begin
        i_rsp_ready <= quiet || ($urandom_range(0, 99) >= 15);
    end

    // watchdog: counts cycles in which no item moves on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles, %0d responses outstanding",
                         $time, STALL_LIMIT, chk_pending);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic t_req make_req(input logic [REQ_W-1:0]   kind,
                                      input logic [VALUE_W-1:0] value,
                                      input logic [INDEX_W-1:0] pos);
        t_req r;
        r.req_type   = kind;
        r.push_value = value;
        r.peek_index = pos;
        return r;
    endfunction

    // random request: push with the given weight, the rest split among the other kinds
    function automatic t_req pick_request(input int push_pct);
        t_req r;
        int   roll;
        r.push_value = $urandom;
        // mostly a valid index, sometimes anything the field can hold
        if (fill > 0 && $urandom_range(0, 3) != 0) begin
            r.peek_index = INDEX_W'($urandom_range(1, fill));
        end else begin
            r.peek_index = INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
        end
        if ($urandom_range(0, 99) < push_pct) begin
            r.req_type = REQ_PUSH;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                r.req_type = REQ_POP;
            end else if (roll < 75) begin
                r.req_type = REQ_PEEK;
            end else if (roll < 90) begin
                r.req_type = REQ_FLIP;
            end else if (roll < 94) begin
                r.req_type = REQ_CLEAR;
            end else begin
                // unused codes above clear, ignored by the block
                r.req_type = REQ_W'($urandom_range(REQ_CLEAR + 1, (1 << REQ_W) - 1));
            end
        end
        return r;
    endfunction

    // one request item: optional idle gap, then hold valid until the handshake.
    // valid is only dropped when a gap follows, so it never gets two updates in one step
    task automatic send_item(input t_req r);
        int gap;
        gap = 0;
        if (!quiet) begin
            while (gap < 8 && $urandom_range(0, 99) < 15) gap++;
        end
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        kind_count[r.req_type]++;
        case (r.req_type)
            REQ_PUSH:  if (fill < DEPTH) fill++;
            REQ_POP:   if (fill > 0) fill--;
            REQ_CLEAR: fill = 0;
            default: begin
            end
        endcase
    endtask

    initial begin
        t_req r;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_req       = '0;
        fill        = 0;
        quiet       = 1'b0;
        foreach (kind_count[k]) kind_count[k] = 0;

        // synchronous reset, held low before release
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // pop, peek and flip on an empty stack
        send_item(make_req(REQ_POP,  '0, 9'd1));
        send_item(make_req(REQ_PEEK, '0, 9'd1));
        send_item(make_req(REQ_PEEK, '0, '0));
        send_item(make_req(REQ_FLIP, '0, '0));
        // smallest word, then flip of a single entry changes nothing
        send_item(make_req(REQ_PUSH, '0, '0));
        send_item(make_req(REQ_FLIP, '0, '0));
        send_item(make_req(REQ_PUSH, '1, '1));
        send_item(make_req(REQ_PUSH, 32'hA5A5_5A5A, '0));
        // bad peek indexes on a stack of three: zero, one past the bottom, all ones
        send_item(make_req(REQ_PEEK, '0, '0));
        send_item(make_req(REQ_PEEK, '0, 9'd4));
        send_item(make_req(REQ_PEEK, '0, '1));
        // bottom entry, then flip so the bottom becomes the top
        send_item(make_req(REQ_PEEK, '0, 9'd3));
        send_item(make_req(REQ_FLIP, '0, '0));
        send_item(make_req(REQ_PEEK, '0, 9'd1));
        send_item(make_req(REQ_POP,  '0, '0));
        send_item(make_req(REQ_PUSH, $urandom, '0));
        send_item(make_req(REQ_PEEK, '0, 9'd2));
        // clear, then pop after clear underflows
        send_item(make_req(REQ_CLEAR, '0, '0));
        send_item(make_req(REQ_POP,   '0, '0));
        // unused request codes must leave the stack alone
        for (int c = REQ_CLEAR + 1; c < (1 << REQ_W); c++) begin
            send_item(make_req(REQ_W'(c), $urandom,
                               INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1))));
        end
        send_item(make_req(REQ_PUSH, $urandom, '0));
        send_item(make_req(REQ_PEEK, '0, 9'd1));

        // ---- random part ----
        // mixed traffic with growth bias
        repeat (100) send_item(pick_request(40));

        // fill to the brim with no idling on either side, a few peeks and flips mixed in
        quiet = 1'b1;
        while (fill < DEPTH) begin
            r = pick_request(100);
            if ($urandom_range(0, 9) == 0) begin
                r.req_type = ($urandom_range(0, 1) != 0) ? REQ_PEEK : REQ_FLIP;
            end
            send_item(r);
        end
        quiet = 1'b0;

        // pushes on a full stack overflow; peek the deepest entry and one beyond
        repeat (4) send_item(make_req(REQ_PUSH, $urandom, '0));
        send_item(make_req(REQ_PEEK, '0, INDEX_W'(DEPTH)));
        send_item(make_req(REQ_PEEK, '0, INDEX_W'(DEPTH + 1)));
        send_item(make_req(REQ_FLIP, '0, '0));
        send_item(make_req(REQ_PEEK, '0, 9'd1));
        send_item(make_req(REQ_PEEK, '0, INDEX_W'(DEPTH)));
        send_item(make_req(REQ_POP,  '0, '0));
        send_item(make_req(REQ_PUSH, $urandom, '0));
        send_item(make_req(REQ_PUSH, $urandom, '0));

        // shrinking traffic from a deep stack
        repeat (100) send_item(pick_request(25));

        // back to a fresh stack for a last short mix
        send_item(make_req(REQ_CLEAR, '0, '0));
        repeat (60) send_item(pick_request(40));

        i_req_valid <= 1'b0;

        // wait for every predicted response, then a short tail for stray ones
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("sent %0d push, %0d pop, %0d peek, %0d flip, %0d clear, %0d unused-code items",
                 kind_count[REQ_PUSH], kind_count[REQ_POP], kind_count[REQ_PEEK],
                 kind_count[REQ_FLIP], kind_count[REQ_CLEAR],
                 kind_count[5] + kind_count[6] + kind_count[7]);
        $display("checked %0d responses: %0d overflow, %0d underflow, %0d bad index",
                 chk_checked, chk_overflows, chk_underflows, chk_bad_index);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lsf_pkg.sv
hw/rtl/lsf_store.sv
hw/rtl/lifo_stack_with_peek_and_flip_top.sv
tb/lsf_stack_checker.sv
tb/tb_lifo_stack_with_peek_and_flip_top.sv
